>>> rtl/core/power_zone_time_accumulator_assert.svh
// Assertion macros shared by the power zone accumulator RTL.
`ifndef POWER_ZONE_TIME_ACCUMULATOR_ASSERT_SVH
`define POWER_ZONE_TIME_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PZTA_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("power zone accumulator check failed");

// Next-cycle implication, disabled while reset is low.
`define PZTA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("power zone accumulator check failed");

`endif

>>> rtl/core/pzta_pkg.sv
// Shared constants, types and zone bound table for the power zone accumulator.
package pzta_pkg;

  localparam int ZONE_COUNT_DEF = 7;

  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int ACTION_W   = 2;
  localparam int POWER_W    = 16;
  localparam int TIME_W     = 32;
  localparam int QUERY_W    = 4;
  localparam int ZONE_OUT_W = 3;
  localparam int ZSEC_W     = 23;
  localparam int TSEC_W     = 25;
  localparam int SUM_W      = 35;
  localparam int PCT_W      = 14;
  localparam int SCALED_W   = 23;
  localparam int BOUND_W    = 26;
  localparam int QUOT_W     = 26;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 2'd2;

  localparam logic [CFG_W-1:0] DEF_THRESHOLD = 12'd200;
  localparam logic [CFG_W-1:0] DEF_MIN_POWER = 12'd50;
  localparam logic [CFG_W-1:0] DEF_MAX_POWER = 12'd1950;

  localparam logic [PCT_W-1:0] PCT_SCALE = 14'd100;
  localparam logic [PCT_W-1:0] LAST_PCT  = 14'd10000;

  localparam logic [PCT_W-1:0] INNER_PCT [15] = '{
    14'd55, 14'd75, 14'd90, 14'd105, 14'd120, 14'd150,
    14'd200, 14'd250, 14'd300, 14'd400, 14'd500, 14'd600, 14'd700, 14'd800, 14'd900
  };

  // x/1000 = (x>>3)/125; floor(2^38/125) undershoots by less than one
  localparam logic [31:0] RECIP_125   = 32'd2199023255;
  localparam int          RECIP_SHIFT = 38;
  localparam logic [7:0]  DIV_LOW     = 8'd125;

  typedef struct packed {
    logic mul_en;
    logic out_en;
  } div_ctrl_t;

  // upper bound of zone idx in percent of threshold
  function automatic logic [PCT_W-1:0] upper_pct(input int idx, input int count);
    logic [PCT_W-1:0] pct;
    if (idx + 1 >= count || idx >= 15) begin
      pct = LAST_PCT;
    end else begin
      pct = INNER_PCT[idx];
    end
    return pct;
  endfunction

endpackage

>>> rtl/core/pzta_div1000.sv
// Two-stage divide by 1000 (pre-shifted dividend, reciprocal multiply, one correction).
module pzta_div1000 (
  input  logic                       clk,
  input  pzta_pkg::div_ctrl_t        ctrl,
  input  logic [31:0]                dividend,
  output logic [pzta_pkg::QUOT_W-1:0] quotient
);
  import pzta_pkg::*;

  logic [31:0]       y_r;
  logic [63:0]       prod_r;
  logic [QUOT_W-1:0] quot_r;

  logic [QUOT_W-1:0] q_est;
  logic [32:0]       q_mul;
  logic [32:0]       rem;
  logic [QUOT_W-1:0] q_fix;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      y_r    <= dividend;
      prod_r <= 64'(dividend) * 64'(RECIP_125);
    end
  end

  always_comb begin
    q_est = prod_r[63:RECIP_SHIFT];
    q_mul = 33'(q_est) * 33'(DIV_LOW);
    rem   = 33'(y_r) - q_mul;
    q_fix = (rem >= 33'(DIV_LOW)) ? q_est + QUOT_W'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      quot_r <= q_fix;
    end
  end

  assign quotient = quot_r;

endmodule

>>> rtl/core/power_zone_time_accumulator.sv
// Power zone time accumulator: classify power samples, sum time per zone, report seconds.
//
//  port group | dir | handshake          | word
//  in_*       | in  | in_valid/in_stall  | action, power, timestamp, query zone
//  out_*      | out | out_valid/out_stall| current zone, zone/total/max seconds
//  cfg_*      | in  | cfg_we             | threshold, min and max valid power
//
// One word per cycle while out_stall is low; each accepted word passes stages 1-3, then the output register.
// Stage 1 holds the word and updates the statistics as it moves on; stages 2-3
// divide the snapshot by 1000 (32x32 reciprocal multiply, then correction).
// Synchronous active-low reset clears statistics and restores register defaults.
// A stall on out_* backs up the pipe; in_stall rises only when every stage is full.
`include "power_zone_time_accumulator_assert.svh"

module power_zone_time_accumulator #(
  parameter int ZONE_COUNT = pzta_pkg::ZONE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pzta_pkg::ACTION_W-1:0]   in_action,
  input  logic [pzta_pkg::POWER_W-1:0]    in_power_watts,
  input  logic [pzta_pkg::TIME_W-1:0]     in_time_ms,
  input  logic [pzta_pkg::QUERY_W-1:0]    in_query_zone,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pzta_pkg::ZONE_OUT_W-1:0] out_current_zone,
  output logic [pzta_pkg::ZSEC_W-1:0]     out_zone_seconds,
  output logic [pzta_pkg::TSEC_W-1:0]     out_total_seconds,
  output logic [pzta_pkg::ZSEC_W-1:0]     out_max_seconds,
  input  logic                            cfg_we,
  input  logic [pzta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pzta_pkg::CFG_W-1:0]      cfg_wdata
);
  import pzta_pkg::*;

  localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

  // configuration
  logic [BOUND_W-1:0] bound_r [ZONE_COUNT];
  logic [CFG_W-1:0]   min_r;
  logic [CFG_W-1:0]   max_r;

  // statistics
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [31:0]       zone_ms_r [ZONE_COUNT];
  logic [31:0]       zone_ms_nxt [ZONE_COUNT];
  logic [ZW-1:0]     active_r, active_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [31:0]       peak_r, peak_nxt;

  // pipeline
  logic                  v1_r, v2_r, v3_r, ov_r;
  logic [ACTION_W-1:0]   act1_r;
  logic [POWER_W-1:0]    pow1_r;
  logic [TIME_W-1:0]     time1_r;
  logic [QUERY_W-1:0]    q1_r;
  logic [ZONE_OUT_W-1:0] zone2_r, zone3_r, zone4_r;
  logic [31:0]           qms2_r;
  logic [SUM_W-1:0]      sum2_r;
  logic [31:0]           peak2_r;

  logic rdy1, rdy2, rdy3, rdy4, upd;

  logic [SCALED_W-1:0] scaled;
  logic [ZONE_COUNT-1:0] lt, hit;
  logic                found, no_last, rejected, zero_delta, do_acc, q_ok;
  logic [TIME_W-1:0]   delta;
  logic [32:0]         zsum [ZONE_COUNT];
  logic [31:0]         zsat [ZONE_COUNT];
  logic [31:0]         hit_new, hit_old, added;
  logic [SUM_W:0]      sum_add;
  logic [ZW-1:0]       hit_idx;
  logic [31:0]         qms;

  div_ctrl_t         div_ctrl;
  logic [QUOT_W-1:0] q_zone, q_sum, q_peak;

  // handshake: a stage loads when empty or when its successor moves
  always_comb begin
    rdy4     = !ov_r || !out_stall;
    rdy3     = !v3_r || rdy4;
    rdy2     = !v2_r || rdy3;
    rdy1     = !v1_r || rdy2;
    in_stall = !rdy1;
    upd      = v1_r && rdy2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      act1_r  <= in_action;
      pow1_r  <= in_power_watts;
      time1_r <= in_time_ms;
      q1_r    <= in_query_zone;
    end
  end

  // configuration registers; zone bounds are kept pre-scaled by threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= DEF_MIN_POWER;
      max_r <= DEF_MAX_POWER;
      for (int i = 0; i < ZONE_COUNT; i++) begin
        bound_r[i] <= BOUND_W'(upper_pct(i, ZONE_COUNT)) * BOUND_W'(DEF_THRESHOLD);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: begin
          for (int i = 0; i < ZONE_COUNT; i++) begin
            bound_r[i] <= BOUND_W'(upper_pct(i, ZONE_COUNT)) * BOUND_W'(cfg_wdata);
          end
        end
        REG_MIN_POWER: min_r <= cfg_wdata;
        REG_MAX_POWER: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classification and per-zone saturating adds
  always_comb begin
    scaled     = SCALED_W'(pow1_r) * SCALED_W'(PCT_SCALE);
    delta      = time1_r - last_time_r;
    no_last    = (last_time_r == '0);
    rejected   = (pow1_r < POWER_W'(min_r)) || (pow1_r > POWER_W'(max_r));
    zero_delta = (delta == '0);
    for (int i = 0; i < ZONE_COUNT; i++) begin
      lt[i]   = BOUND_W'(scaled) < bound_r[i];
      zsum[i] = {1'b0, zone_ms_r[i]} + {1'b0, delta};
      zsat[i] = zsum[i][32] ? '1 : zsum[i][31:0];
    end
    // bounds rise with the zone, so the first hit is where lt turns on
    hit[0] = lt[0];
    for (int i = 1; i < ZONE_COUNT; i++) begin
      hit[i] = lt[i] && !lt[i-1];
    end
    found   = lt[ZONE_COUNT-1];
    hit_new = '0;
    hit_old = '0;
    hit_idx = '0;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      if (hit[i]) begin
        hit_new = hit_new | zsat[i];
        hit_old = hit_old | zone_ms_r[i];
        hit_idx = hit_idx | ZW'(i);
      end
    end
    added   = hit_new - hit_old;
    sum_add = {1'b0, sum_r} + (SUM_W + 1)'(added);
    do_acc  = (act1_r == ACT_ADD) && !no_last && !rejected && !zero_delta && found;
  end

  always_comb begin
    last_time_nxt = last_time_r;
    active_nxt    = active_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      zone_ms_nxt[i] = (do_acc && hit[i]) ? zsat[i] : zone_ms_r[i];
    end
    case (act1_r)
      ACT_CLEAR: begin
        last_time_nxt = '0;
        active_nxt    = '0;
        sum_nxt       = '0;
        peak_nxt      = '0;
        for (int i = 0; i < ZONE_COUNT; i++) begin
          zone_ms_nxt[i] = '0;
        end
      end
      ACT_ADD: begin
        if (no_last || rejected || !zero_delta) begin
          last_time_nxt = time1_r;
        end
        if (do_acc) begin
          active_nxt = hit_idx;
          sum_nxt    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          peak_nxt   = (hit_new > peak_r) ? hit_new : peak_r;
        end
      end
      default: ;
    endcase
    q_ok = int'(q1_r) < ZONE_COUNT;
    qms  = q_ok ? zone_ms_nxt[q1_r[ZW-1:0]] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      active_r    <= '0;
      sum_r       <= '0;
      peak_r      <= '0;
      for (int i = 0; i < ZONE_COUNT; i++) begin
        zone_ms_r[i] <= '0;
      end
    end else if (upd) begin
      last_time_r <= last_time_nxt;
      active_r    <= active_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      for (int i = 0; i < ZONE_COUNT; i++) begin
        zone_ms_r[i] <= zone_ms_nxt[i];
      end
    end
  end

  // snapshot of the post-update statistics, then the divide stages
  always_ff @(posedge clk) begin
    if (rdy2) begin
      zone2_r <= ZONE_OUT_W'(active_nxt);
      qms2_r  <= qms;
      sum2_r  <= sum_nxt;
      peak2_r <= peak_nxt;
    end
    if (rdy3) zone3_r <= zone2_r;
    if (rdy4) zone4_r <= zone3_r;
  end

  assign div_ctrl.mul_en = rdy3;
  assign div_ctrl.out_en = rdy4;

  pzta_div1000 u_div_zone (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend ({3'b000, qms2_r[31:3]}),
    .quotient (q_zone)
  );

  pzta_div1000 u_div_sum (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (sum2_r[SUM_W-1:3]),
    .quotient (q_sum)
  );

  pzta_div1000 u_div_peak (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend ({3'b000, peak2_r[31:3]}),
    .quotient (q_peak)
  );

  assign out_valid         = ov_r;
  assign out_current_zone  = zone4_r;
  assign out_zone_seconds  = ZSEC_W'(q_zone);
  assign out_max_seconds   = ZSEC_W'(q_peak);
  assign out_total_seconds = q_sum[TSEC_W] ? '1 : q_sum[TSEC_W-1:0];

  `PZTA_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall,
                   v1_r && v2_r && v3_r && ov_r)
  `PZTA_ASSERT_NEXT(a_clear_zeroes_stats, clk, rst_n, upd && (act1_r == ACT_CLEAR),
                    (sum_r == '0) && (peak_r == '0) && (last_time_r == '0))
  `PZTA_ASSERT_NOW(a_sum_covers_peak, clk, rst_n, 1'b1, sum_r >= SUM_W'(peak_r))
  `PZTA_ASSERT_NOW(a_active_in_range, clk, rst_n, 1'b1, int'(active_r) < ZONE_COUNT)

endmodule

>>> sim/power_zone_time_accumulator_checker.sv
// Checker for the power zone accumulator: tracks registers, predicts each report word and compares.
`timescale 1ns / 1ps

module power_zone_time_accumulator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [pzta_pkg::ACTION_W-1:0]   in_action,
  input  logic [pzta_pkg::POWER_W-1:0]    in_power_watts,
  input  logic [pzta_pkg::TIME_W-1:0]     in_time_ms,
  input  logic [pzta_pkg::QUERY_W-1:0]    in_query_zone,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [pzta_pkg::ZONE_OUT_W-1:0] out_current_zone,
  input  logic [pzta_pkg::ZSEC_W-1:0]     out_zone_seconds,
  input  logic [pzta_pkg::TSEC_W-1:0]     out_total_seconds,
  input  logic [pzta_pkg::ZSEC_W-1:0]     out_max_seconds,
  input  logic                            cfg_we,
  input  logic [pzta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pzta_pkg::CFG_W-1:0]      cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import pzta_pkg::*;

  localparam int ZONES = 7;
  localparam int unsigned BOUND_PCT [ZONES] = '{55, 75, 90, 105, 120, 150, 10000};

  typedef struct packed {
    logic [ZONE_OUT_W-1:0] zone;
    logic [ZSEC_W-1:0]     zone_sec;
    logic [TSEC_W-1:0]     total_sec;
    logic [ZSEC_W-1:0]     peak_sec;
  } zone_report_t;

  logic [CFG_W-1:0]      ftp_w;
  logic [CFG_W-1:0]      floor_w;
  logic [CFG_W-1:0]      ceil_w;
  logic [TIME_W-1:0]     last_ms;
  logic [31:0]           zone_ms [ZONES];
  logic [ZONE_OUT_W-1:0] cur_zone;
  logic [SUM_W-1:0]      sum_ms;
  logic [31:0]           peak_ms;
  zone_report_t          report_q [$];
  zone_report_t          seen;

  task automatic clear_tallies();
    last_ms = '0;
    for (int z = 0; z < ZONES; z++) zone_ms[z] = '0;
    cur_zone = '0;
    sum_ms = '0;
    peak_ms = '0;
  endtask

  // apply one accepted word to the tallies and queue the report it produces
  task automatic tally_word(input logic [ACTION_W-1:0] act, input logic [POWER_W-1:0] pwr,
                            input logic [TIME_W-1:0] t, input logic [QUERY_W-1:0] q);
    logic [63:0]       scaled;
    logic [31:0]       delta;
    logic [32:0]       grown;
    logic [31:0]       added;
    logic [SUM_W:0]    wide_sum;
    logic [SUM_W-1:0]  quot;
    logic [31:0]       zq;
    bit                placed;
    zone_report_t      r;
    scaled = 64'(pwr) * 64'd100;
    if (act == ACT_ADD) begin
      if (last_ms == '0 || pwr < floor_w || pwr > ceil_w) begin
        last_ms = t;
      end else begin
        delta = t - last_ms;
        if (delta != '0) begin
          placed = 1'b0;
          for (int z = 0; z < ZONES; z++) begin
            if (!placed && scaled < 64'(BOUND_PCT[z]) * 64'(ftp_w)) begin
              placed = 1'b1;
              grown = {1'b0, zone_ms[z]} + {1'b0, delta};
              if (grown[32]) grown = {1'b0, 32'hFFFF_FFFF};
              added = grown[31:0] - zone_ms[z];
              zone_ms[z] = grown[31:0];
              wide_sum = {1'b0, sum_ms} + (SUM_W + 1)'(added);
              sum_ms = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
              if (zone_ms[z] > peak_ms) peak_ms = zone_ms[z];
              cur_zone = z[ZONE_OUT_W-1:0];
            end
          end
          // no zone matched: time still moves on
          last_ms = t;
        end
      end
    end else if (act == ACT_CLEAR) begin
      clear_tallies();
    end
    zq = (q < ZONES) ? zone_ms[q[2:0]] / 32'd1000 : 32'd0;
    quot = sum_ms / 1000;
    r.zone = cur_zone;
    r.zone_sec = zq[ZSEC_W-1:0];
    r.total_sec = (quot > SUM_W'({TSEC_W{1'b1}})) ? '1 : quot[TSEC_W-1:0];
    zq = peak_ms / 32'd1000;
    r.peak_sec = zq[ZSEC_W-1:0];
    report_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ftp_w = DEF_THRESHOLD;
      floor_w = DEF_MIN_POWER;
      ceil_w = DEF_MAX_POWER;
      clear_tallies();
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: ftp_w = cfg_wdata;
          REG_MIN_POWER: floor_w = cfg_wdata;
          REG_MAX_POWER: ceil_w = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        tally_word(in_action, in_power_watts, in_time_ms, in_query_zone);
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("report word arrived with nothing expected");
          fail_count = fail_count + 1;
        end else begin
          seen = report_q.pop_front();
          if (out_current_zone !== seen.zone) begin
            $error("current_zone: expected %0d, got %0d", seen.zone, out_current_zone);
            fail_count = fail_count + 1;
          end
          if (out_zone_seconds !== seen.zone_sec) begin
            $error("zone_seconds: expected %0d, got %0d", seen.zone_sec, out_zone_seconds);
            fail_count = fail_count + 1;
          end
          if (out_total_seconds !== seen.total_sec) begin
            $error("total_seconds: expected %0d, got %0d", seen.total_sec, out_total_seconds);
            fail_count = fail_count + 1;
          end
          if (out_max_seconds !== seen.peak_sec) begin
            $error("max_seconds: expected %0d, got %0d", seen.peak_sec, out_max_seconds);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending <= report_q.size();
  end

endmodule

>>> sim/power_zone_time_accumulator_tb.sv
// Testbench top for the power zone accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module power_zone_time_accumulator_tb;
  import pzta_pkg::*;

  localparam logic [ACTION_W-1:0]  ACT_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 165;
  localparam int EDGE_PCT [7] = '{55, 75, 90, 105, 120, 150, 10000};
  localparam logic [CFG_W-1:0] FTP_SET [PHASES] =
    '{12'd200, 12'd4095, 12'd0, 12'd1, 12'd300, 12'd4095, 12'd250, 12'd150};
  localparam logic [CFG_W-1:0] LO_SET [PHASES] =
    '{12'd50, 12'd0, 12'd0, 12'd0, 12'd100, 12'd4095, 12'd4095, 12'd20};
  localparam logic [CFG_W-1:0] HI_SET [PHASES] =
    '{12'd1950, 12'd4095, 12'd4095, 12'd4095, 12'd900, 12'd4095, 12'd0, 12'd600};
  localparam int IDLE_SET [4]  = '{0, 59, 0, 28};
  localparam int STALL_SET [4] = '{0, 0, 59, 28};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   in_action = ACT_QUERY;
  logic [POWER_W-1:0]    in_power_watts = '0;
  logic [TIME_W-1:0]     in_time_ms = '0;
  logic [QUERY_W-1:0]    in_query_zone = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ZONE_OUT_W-1:0] out_current_zone;
  logic [ZSEC_W-1:0]     out_zone_seconds;
  logic [TSEC_W-1:0]     out_total_seconds;
  logic [ZSEC_W-1:0]     out_max_seconds;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  int                    fail_count;
  int                    pending;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] clock_ms = '0;
  int          cur_ftp = int'(DEF_THRESHOLD);
  int          cur_lo = int'(DEF_MIN_POWER);
  int          cur_hi = int'(DEF_MAX_POWER);

  power_zone_time_accumulator dut (.*);
  power_zone_time_accumulator_checker chk (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [POWER_W-1:0] pwr,
                           input logic [TIME_W-1:0] t, input logic [QUERY_W-1:0] q);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_power_watts <= pwr;
    in_time_ms <= t;
    in_query_zone <= q;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender off until every report word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_limits(input logic [CFG_W-1:0] ftp, input logic [CFG_W-1:0] lo,
                                input logic [CFG_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= ftp;
    @(posedge clk);
    cfg_index <= REG_MIN_POWER;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_POWER;
    cfg_wdata <= hi;
    @(posedge clk);
    // index past the register list, must be ignored
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ftp = int'(ftp);
    cur_lo = int'(lo);
    cur_hi = int'(hi);
  endtask

  task automatic send_random_word();
    logic [ACTION_W-1:0] act;
    logic [QUERY_W-1:0]  q;
    int                  pick;
    int                  z;
    int                  pwr;
    pick = $urandom_range(99);
    if (pick < 3) act = ACT_CLEAR;
    else if (pick < 15) act = ACT_QUERY;
    else if (pick < 19) act = ACT_SPARE;
    else act = ACT_ADD;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      // straddle a zone edge
      z = $urandom_range(6);
      pwr = (EDGE_PCT[z] * cur_ftp + 99) / 100 + $urandom_range(2) - 1;
    end else if (pick <= 7) begin
      pwr = $urandom_range(2 * cur_ftp + 100);
    end else if (pick == 8) begin
      pwr = $urandom_range(65535);
    end else begin
      pwr = ($urandom_range(1) ? cur_lo : cur_hi) + $urandom_range(2) - 1;
    end
    if (pwr < 0) pwr = 0;
    if (pwr > 65535) pwr = 65535;
    pick = $urandom_range(99);
    if (pick < 80) clock_ms = clock_ms + $urandom_range(4000, 1);
    else if (pick < 86) clock_ms = clock_ms;
    else if (pick < 92) clock_ms = $urandom;
    else if (pick < 95) clock_ms = '0;
    else clock_ms = clock_ms + $urandom_range(32'h7FFF_FFFF, 1000000);
    q = ($urandom_range(99) < 85) ? QUERY_W'($urandom_range(6))
                                  : QUERY_W'($urandom_range(15, 7));
    send_word(act, pwr[POWER_W-1:0], clock_ms, q);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: threshold 200, valid power 50..1950
    send_word(ACT_QUERY, 16'd0, 32'd0, 4'd0);
    send_word(ACT_ADD, 16'd150, 32'd1000, 4'd0);       // first sample only latches
    send_word(ACT_ADD, 16'd109, 32'd3500, 4'd0);
    send_word(ACT_ADD, 16'd110, 32'd4500, 4'd1);       // exactly on the zone 1 edge
    send_word(ACT_ADD, 16'd110, 32'd4500, 4'd1);       // no time elapsed
    send_word(ACT_ADD, 16'd49, 32'd6000, 4'd0);        // under the floor
    send_word(ACT_ADD, 16'd1951, 32'd7000, 4'd6);      // over the ceiling
    send_word(ACT_ADD, 16'd1950, 32'd9000, 4'd6);
    send_word(ACT_ADD, 16'd50, 32'd10000, 4'd0);
    send_word(ACT_ADD, 16'hFFFF, 32'd11000, 4'd2);
    send_word(ACT_ADD, 16'd299, 32'd15000, 4'd5);
    send_word(ACT_ADD, 16'd300, 32'd17000, 4'd6);
    send_word(ACT_SPARE, 16'd0, 32'hFFFF_FFFF, 4'd15);
    send_word(ACT_QUERY, 16'd0, 32'd0, 4'd7);
    send_word(ACT_ADD, 16'd200, 32'd0, 4'd3);          // wraps, then time reads as unset
    send_word(ACT_ADD, 16'd200, 32'h8000_0000, 4'd3);
    send_word(ACT_ADD, 16'd200, 32'hFFFF_FFFF, 4'd3);  // zone 3 saturates
    send_word(ACT_ADD, 16'd179, 32'h7FFF_FFFE, 4'd2);
    send_word(ACT_CLEAR, 16'd0, 32'd0, 4'd3);
    send_word(ACT_QUERY, 16'd0, 32'd0, 4'd2);
    send_word(ACT_ADD, 16'd239, 32'd500, 4'd4);
    send_word(ACT_ADD, 16'd240, 32'd2600, 4'd5);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_pct = IDLE_SET[ph % 4];
      stall_pct = STALL_SET[ph % 4];
      program_limits(FTP_SET[ph], LO_SET[ph], HI_SET[ph]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 2 && n == PHASE_WORDS / 2) drain();
        send_random_word();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("power_zone_time_accumulator verification clean");
    end else begin
      $display("power_zone_time_accumulator verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("power_zone_time_accumulator verification failed");
    $finish;
  end

endmodule
